// File: sv/sdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdb_pkg
// Types and constants of the screen density bucket unit.
// ----------------------------------------------------------------------------
package sdb_pkg;

  typedef struct packed {
    logic [12:0] x_pixels;
    logic [12:0] y_pixels;
    logic [11:0] width_mm;
    logic [11:0] height_mm;
  } in_item_t;

  typedef struct packed {
    logic [9:0] density_dpi;
    logic       size_error;
  } out_item_t;

  localparam int RAD_W      = 28;
  localparam int ROOT_W     = 30;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIN_W      = 24;
  localparam int NUM_THR    = 6;

  localparam logic [19:0] INCH_PER_MM_Q24 = 20'd660521;
  localparam logic [DIN_W-1:0] SMALL_DIAG_Q16 = 24'd183501;
  localparam logic [32:0] SMALL_SCALE = 33'd917504;

  typedef logic [9:0] thr_arr_t [NUM_THR];
  typedef logic [9:0] dpi_arr_t [NUM_THR+1];

  localparam thr_arr_t THRESH = '{10'd140, 10'd186, 10'd226, 10'd280, 10'd400, 10'd560};
  localparam dpi_arr_t DPI    = '{10'd120, 10'd160, 10'd213, 10'd240, 10'd320, 10'd480,
                                  10'd640};
  localparam int THR_186 = 1;

endpackage

// File: sv/screen_density_bucket_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_density_bucket_unit
// Classifies a panel into a standard density bucket from resolution and size.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled. It passes an
// input register, a squares stage, 30 square root stages (one root bit each,
// pixel and millimetre diagonals side by side), a millimetre-to-inch
// multiply, a threshold compare stage and the output register. A stall on
// the output freezes the whole pipeline; nothing is dropped or repeated.
module screen_density_bucket_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sdb_pkg::out_item_t out_item
);
  import sdb_pkg::*;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  in_item_t in_r;
  logic     v0_r;

  logic [RAD_W-1:0] sp_r, sd_r;
  logic             v1_r, e1_r;

  logic vq_r [SQRT_STEPS];
  logic eq_r [SQRT_STEPS];

  logic [ROOT_W-1:0] p_root, d_root;

  logic [ROOT_W-1:0] p1_r;
  logic [47:0]       dprod_r;
  logic              v2_r, e2_r;

  logic [NUM_THR-1:0] ge_r, ge2_r;
  logic               small_r, v3_r, e3_r;

  out_item_t out_r;
  logic      out_valid_r;

  // squares
  logic [25:0] xx, yy;
  logic [23:0] ww, hh;
  logic [RAD_W-1:0] sp_nxt, sd_nxt;
  assign xx     = in_r.x_pixels * in_r.x_pixels;
  assign yy     = in_r.y_pixels * in_r.y_pixels;
  assign ww     = in_r.width_mm * in_r.width_mm;
  assign hh     = in_r.height_mm * in_r.height_mm;
  assign sp_nxt = {2'b00, xx} + {2'b00, yy};
  assign sd_nxt = {4'b0000, ww} + {4'b0000, hh};

  sdb_isqrt u_p_sqrt (.clk(clk), .en(en), .rad_in(sp_r), .root_out(p_root));
  sdb_isqrt u_d_sqrt (.clk(clk), .en(en), .rad_in(sd_r), .root_out(d_root));

  // threshold compares
  logic [DIN_W-1:0]   din;
  logic [32:0]        p5;
  logic [NUM_THR-1:0] ge_nxt, ge2_nxt;
  assign din = dprod_r[47:24];
  assign p5  = {1'b0, p1_r, 2'b00} + {3'b000, p1_r};

  always_comb begin
    for (int t = 0; t < NUM_THR; t++) begin
      ge_nxt[t]  = {4'b0000, p1_r} >= ({10'd0, din} * {24'd0, THRESH[t]});
      ge2_nxt[t] = p5 >= (SMALL_SCALE * {23'd0, THRESH[t]});
    end
  end

  // bucket select
  logic [NUM_THR-1:0] g;
  out_item_t          out_nxt;
  always_comb begin
    g = (small_r && ge_r[THR_186]) ? ge2_r : ge_r;
    out_nxt.density_dpi = DPI[0];
    for (int t = 0; t < NUM_THR; t++) begin
      if (g[t]) out_nxt.density_dpi = DPI[t+1];
    end
    out_nxt.size_error = e3_r;
    if (e3_r) out_nxt.density_dpi = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r    <= in_item;
      sp_r    <= sp_nxt;
      sd_r    <= sd_nxt;
      e1_r    <= (in_r.width_mm == '0) || (in_r.height_mm == '0);
      eq_r[0] <= e1_r;
      for (int k = 1; k < SQRT_STEPS; k++) eq_r[k] <= eq_r[k-1];
      p1_r    <= p_root;
      dprod_r <= {18'd0, d_root} * {28'd0, INCH_PER_MM_Q24};
      e2_r    <= eq_r[SQRT_STEPS-1];
      ge_r    <= ge_nxt;
      ge2_r   <= ge2_nxt;
      small_r <= din < SMALL_DIAG_Q16;
      e3_r    <= e2_r;
      out_r   <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) vq_r[k] <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      vq_r[0]     <= v1_r;
      for (int k = 1; k < SQRT_STEPS; k++) vq_r[k] <= vq_r[k-1];
      v2_r        <= vq_r[SQRT_STEPS-1];
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: sv/sdb_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdb_isqrt
// Pipelined restoring square root of (rad_in << 32), one root bit per stage.
// ----------------------------------------------------------------------------
module sdb_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sdb_pkg::RAD_W-1:0]  rad_in,
  output logic [sdb_pkg::ROOT_W-1:0] root_out
);
  import sdb_pkg::*;

  logic [RAD_W-1:0]  rad_r  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [1:0]        pair;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_nxt;
      logic [ROOT_W-1:0] root_nxt;

      if (k == 0) begin : g_first
        assign rad_prev  = rad_in;
        assign rem_prev  = '0;
        assign root_prev = '0;
      end else begin : g_next
        assign rad_prev  = rad_r[k-1];
        assign rem_prev  = rem_r[k-1];
        assign root_prev = root_r[k-1];
      end

      if (k < RAD_W / 2) begin : g_bits
        assign pair = rad_prev[RAD_W-1-2*k -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end

      assign rem_sh   = {rem_prev[REM_W-3:0], pair};
      assign trial    = {1'b0, root_prev, 2'b01};
      assign take     = rem_sh >= trial;
      assign rem_nxt  = take ? rem_sh - trial : rem_sh;
      assign root_nxt = {root_prev[ROOT_W-2:0], take};

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k]  <= rad_prev;
          rem_r[k]  <= rem_nxt;
          root_r[k] <= root_nxt;
        end
      end
    end
  endgenerate

  assign root_out = root_r[SQRT_STEPS-1];

endmodule
